// ===== rtl/mme_pkg.sv =====
`timescale 1ns / 1ps

package mme_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int DIM_W   = 4;
  localparam int VAL_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = 2 * VAL_W;
  // room for MAX_DIM full products plus sign
  localparam int ACC_W   = PROD_W + $clog2(MAX_DIM);
  localparam int Q_W     = ACC_W - FRAC_W;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_W - 1);

  typedef enum logic [1:0] {
    REQ_LOAD_LEFT  = 2'd0,
    REQ_LOAD_RIGHT = 2'd1,
    REQ_COMPUTE    = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    CFG_ROW_COUNT   = 2'd0,
    CFG_INNER_COUNT = 2'd1,
    CFG_COL_COUNT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              wr_left;
    logic              wr_right;
    logic              rd_en;
    logic              rd_first;
    logic              rd_last;
    logic [ADDR_W-1:0] left_addr;
    logic [ADDR_W-1:0] right_addr;
    logic              load_out;
    logic [IDX_W-1:0]  out_row;
    logic [IDX_W-1:0]  out_col;
    logic              out_last;
  } mme_cmd_t;

  typedef struct packed {
    logic acc_done;
    logic out_busy;
  } mme_status_t;

endpackage

// ===== rtl/mme_ctrl.sv =====
`timescale 1ns / 1ps

module mme_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_req_type,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [mme_pkg::DIM_W-1:0] cfg_data,
  output mme_pkg::mme_cmd_t         cmd,
  input  mme_pkg::mme_status_t      status
);
  import mme_pkg::*;

  state_t           state_r, state_nxt;
  logic [DIM_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [DIM_W-1:0] inner_cnt_r, inner_cnt_nxt;
  logic [DIM_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [IDX_W-1:0] r_r, r_nxt;
  logic [IDX_W-1:0] c_r, c_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] row_lim, inner_lim, col_lim;
  logic             last_elem;
  logic             start;

  // size register to last index: zero acts as one, oversize as MAX_DIM
  function automatic logic [IDX_W-1:0] dim_lim(input logic [DIM_W-1:0] v);
    logic [IDX_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (32'(v) > MAX_DIM) begin
      res = IDX_W'(MAX_DIM - 1);
    end else begin
      res = IDX_W'(v - DIM_W'(1));
    end
    return res;
  endfunction

  assign row_lim   = dim_lim(row_cnt_r);
  assign inner_lim = dim_lim(inner_cnt_r);
  assign col_lim   = dim_lim(col_cnt_r);
  assign last_elem = (r_r == row_lim) && (c_r == col_lim);
  assign start     = (state_r == ST_IDLE) && in_valid && (in_req_type == REQ_COMPUTE);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (k_r == inner_lim) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.acc_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status.out_busy) state_nxt = last_elem ? ST_IDLE : ST_RUN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready           = (state_r == ST_IDLE);
    cmd.wr_left        = (state_r == ST_IDLE) && in_valid && (in_req_type == REQ_LOAD_LEFT);
    cmd.wr_right       = (state_r == ST_IDLE) && in_valid && (in_req_type == REQ_LOAD_RIGHT);
    cmd.rd_en          = (state_r == ST_RUN);
    cmd.rd_first       = (k_r == '0);
    cmd.rd_last        = (k_r == inner_lim);
    cmd.left_addr      = {r_r, k_r};
    cmd.right_addr     = {k_r, c_r};
    cmd.load_out       = (state_r == ST_EMIT) && !status.out_busy;
    cmd.out_row        = r_r;
    cmd.out_col        = c_r;
    cmd.out_last       = last_elem;
  end

  // index counters
  always_comb begin
    r_nxt = r_r;
    c_nxt = c_r;
    k_nxt = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          r_nxt = '0;
          c_nxt = '0;
          k_nxt = '0;
        end
      end
      ST_RUN: begin
        k_nxt = (k_r == inner_lim) ? '0 : k_r + IDX_W'(1);
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          if (c_r == col_lim) begin
            c_nxt = '0;
            r_nxt = r_r + IDX_W'(1);
          end else begin
            c_nxt = c_r + IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // configuration writes
  always_comb begin
    row_cnt_nxt   = row_cnt_r;
    inner_cnt_nxt = inner_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ROW_COUNT:   row_cnt_nxt   = cfg_data;
        CFG_INNER_COUNT: inner_cnt_nxt = cfg_data;
        CFG_COL_COUNT:   col_cnt_nxt   = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_cnt_r   <= DIM_W'(MAX_DIM);
      inner_cnt_r <= DIM_W'(MAX_DIM);
      col_cnt_r   <= DIM_W'(MAX_DIM);
      r_r         <= '0;
      c_r         <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      inner_cnt_r <= inner_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      k_r         <= k_nxt;
    end
  end

endmodule

// ===== rtl/mme_datapath.sv =====
`timescale 1ns / 1ps

module mme_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [mme_pkg::IDX_W-1:0]        in_row,
  input  logic [mme_pkg::IDX_W-1:0]        in_col,
  input  logic signed [mme_pkg::VAL_W-1:0] in_value,
  input  mme_pkg::mme_cmd_t                cmd,
  output mme_pkg::mme_status_t             status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mme_pkg::IDX_W-1:0]        out_row,
  output logic [mme_pkg::IDX_W-1:0]        out_col,
  output logic signed [mme_pkg::VAL_W-1:0] out_value,
  output logic                             out_last
);
  import mme_pkg::*;

  logic signed [VAL_W-1:0] left_mem  [DEPTH];
  logic signed [VAL_W-1:0] right_mem [DEPTH];

  logic signed [VAL_W-1:0]  a_r, b_r;
  logic                     vld1_r, first1_r, last1_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     vld2_r, first2_r, last2_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     done_r;

  logic signed [ACC_W-1:0]  rnd_sum;
  logic [Q_W-1:0]           rnd_q;
  logic                     sat_pos, sat_neg;
  logic [VAL_W-1:0]         res_value;

  logic                     out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [VAL_W-1:0]  out_value_r;
  logic                     out_last_r;

  // store ports: one write, one registered read each
  always_ff @(posedge clk) begin
    if (cmd.wr_left) left_mem[{in_row, in_col}] <= in_value;
    if (cmd.wr_right) right_mem[{in_row, in_col}] <= in_value;
    if (cmd.rd_en) begin
      a_r <= left_mem[cmd.left_addr];
      b_r <= right_mem[cmd.right_addr];
    end
  end

  assign prod_nxt = a_r * b_r;
  // first term of a dot product loads the accumulator instead of adding
  assign acc_nxt  = first2_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    first1_r <= cmd.rd_first;
    last1_r  <= cmd.rd_last;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    if (vld2_r) acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      vld1_r <= cmd.rd_en;
      vld2_r <= vld1_r;
      done_r <= vld2_r && last2_r;
    end
  end

  // round half up to Q16.16, then saturate
  assign rnd_sum   = acc_r + $signed(RND_HALF);
  assign rnd_q     = rnd_sum[ACC_W-1:FRAC_W];
  assign sat_pos   = !rnd_q[Q_W-1] && (|rnd_q[Q_W-2:VAL_W-1]);
  assign sat_neg   = rnd_q[Q_W-1] && !(&rnd_q[Q_W-2:VAL_W-1]);
  assign res_value = sat_pos ? VAL_MAX : (sat_neg ? VAL_MIN : rnd_q[VAL_W-1:0]);

  // output word register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_row_r   <= cmd.out_row;
      out_col_r   <= cmd.out_col;
      out_value_r <= $signed(res_value);
      out_last_r  <= cmd.out_last;
    end
  end

  assign status.acc_done = done_r;
  assign status.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

// ===== rtl/matrix_multiply_engine.sv =====
`timescale 1ns / 1ps

// Q16.16 matrix multiplier. Load words (req_type 0 left, 1 right) write one
// element at {row, col} and leave the input ready. A compute word emits the
// row_count x col_count product in row-major order, out_last on the final
// element; each element passes through the single shared 32x32 multiply-
// accumulate (one read per store per cycle), then drains the read, multiply
// and accumulate registers, and is rounded and loaded into the output register.
// Products are summed exactly, rounded once half up and saturated to 32 bits.
// Sizes are clamped to 1..8 and may be written only while no compute is in
// flight. Loads are taken while the last result of a run still waits at the
// output.
module matrix_multiply_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_req_type,
  input  logic [mme_pkg::IDX_W-1:0]        in_row,
  input  logic [mme_pkg::IDX_W-1:0]        in_col,
  input  logic signed [mme_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mme_pkg::IDX_W-1:0]        out_row,
  output logic [mme_pkg::IDX_W-1:0]        out_col,
  output logic signed [mme_pkg::VAL_W-1:0] out_value,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]        cfg_data
);
  import mme_pkg::*;

  mme_cmd_t    cmd;
  mme_status_t status;

  mme_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status)
  );

  mme_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_value  (in_value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule

// ===== rtl/mme_checker.sv =====
`timescale 1ns / 1ps

module mme_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [1:0]                       in_req_type,
  input logic [mme_pkg::IDX_W-1:0]        in_row,
  input logic [mme_pkg::IDX_W-1:0]        in_col,
  input logic signed [mme_pkg::VAL_W-1:0] in_value,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [mme_pkg::IDX_W-1:0]        out_row,
  input logic [mme_pkg::IDX_W-1:0]        out_col,
  input logic signed [mme_pkg::VAL_W-1:0] out_value,
  input logic                             out_last,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [1:0]                       cfg_index,
  input logic [mme_pkg::DIM_W-1:0]        cfg_data
);
  import mme_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_row)
      && $stable(out_col) && $stable(out_last))
    else $error("result word changed while stalled");

  // a load finishes in the cycle it is taken
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_LOAD_LEFT || in_req_type == REQ_LOAD_RIGHT)
      |=> in_ready)
    else $error("load word stalled the input");

  // a compute word blocks the input until its run is issued
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_COMPUTE) |=> !in_ready)
    else $error("input open right after compute word");

  // more results of the run follow, so the input stays closed
  a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input open in the middle of a product run");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);
